>>> rtl/snapid_pkg.sv
// ----------------------------------------------------------------------------
// snapid_pkg
// Types and constants shared by the single-neuron adaptive pid block.
// ----------------------------------------------------------------------------
package snapid_pkg;

   // field and state widths
   localparam int ERR_W   = 16;
   localparam int WGT_W   = 32;
   localparam int TOT_W   = 32;
   localparam int RATE_W  = 24;
   localparam int CFG16_W = 16;

   // shared multiplier operand and product widths
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;

   // divider: dividend = |num| * gain, divisor = sum of weight magnitudes
   localparam int DIVD_W  = 79;
   localparam int DIVS_W  = 34;
   localparam int QUO_W   = 47;
   localparam int QCNT_W  = 6;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_OUT_MAX   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DB_RATIO  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_I    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_P    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_D    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_START_WGT = 3'd7;

   typedef struct packed {
      logic signed [ERR_W-1:0] error_in;
      logic                    restart;
   } req_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] drive;
      logic                    in_deadband;
      logic                    clamped;
   } rsp_type;

endpackage

>>> rtl/snapid_mul.sv
// ----------------------------------------------------------------------------
// snapid_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module snapid_mul
   import snapid_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // full-width product of the sign-extended operands
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/snapid_div.sv
// ----------------------------------------------------------------------------
// snapid_div
// Restoring divider, one quotient bit per cycle, quotient known to fit.
// ----------------------------------------------------------------------------
module snapid_div
   import snapid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic [QUO_W-1:0]  quotient,
   output logic              done
);

   logic [DIVS_W-1:0] rem_ff,  rem_in;
   logic [QUO_W-1:0]  dq_ff,   dq_in;
   logic [QCNT_W-1:0] cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   trial;
   logic              ge;

   // shift in the next dividend bit and test against the divisor
   assign trial = {rem_ff, dq_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = DIVS_W'(dividend[DIVD_W-1:QUO_W]);
         dq_in   = dividend[QUO_W-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIVS_W'(trial - {1'b0, divisor}) : trial[DIVS_W-1:0];
         dq_in  = {dq_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == QCNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = dq_ff;
   assign done     = done_ff;

endmodule

>>> rtl/single_neuron_adaptive_pid.sv
// ----------------------------------------------------------------------------
// single_neuron_adaptive_pid
// Single-neuron adaptive pid controller with learned integral, proportional
// and difference weights.
// ----------------------------------------------------------------------------
// Usage: one error sample per req_ transaction (error_in Q3.12, restart
// reloads the weights from start_weight and clears the sums first). Each
// sample gives exactly one rsp_ transaction carrying the clamped drive and
// the deadband and clamp flags. Settings go in over the csr_ write port while
// the block is idle; each write takes effect at once.
// Paths: inside the deadband the sequencer goes from the deadband test
// straight to the clamp and output, and when all weights are zero it skips
// the divide. The long path is set by the wait on the 47-step restoring
// divider that normalises the weighted sum, plus the sixteen products
// issued one after another on the single shared multiplier. One sample is
// in work at a time: req_stall is high from acceptance until the result is
// loaded into the output register, so no new sample is taken before then.
// A result waiting under rsp_stall does not block the next sample; a second
// result waits inside until the output register is free.
// Reset: settings take their default values, weights load 1.0 and the
// error sums clear.
// ----------------------------------------------------------------------------
module single_neuron_adaptive_pid
   import snapid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DB    = 5'd1;
   localparam logic [4:0] S_M0    = 5'd2;
   localparam logic [4:0] S_M1    = 5'd3;
   localparam logic [4:0] S_M2    = 5'd4;
   localparam logic [4:0] S_M3    = 5'd5;
   localparam logic [4:0] S_ABS   = 5'd6;
   localparam logic [4:0] S_G0    = 5'd7;
   localparam logic [4:0] S_G1    = 5'd8;
   localparam logic [4:0] S_G2    = 5'd9;
   localparam logic [4:0] S_DIV   = 5'd10;
   localparam logic [4:0] S_VAL   = 5'd11;
   localparam logic [4:0] S_CLAMP = 5'd12;
   localparam logic [4:0] S_ED    = 5'd13;
   localparam logic [4:0] S_EDL   = 5'd14;
   localparam logic [4:0] S_LA    = 5'd15;
   localparam logic [4:0] S_LAB   = 5'd16;
   localparam logic [4:0] S_LR0   = 5'd17;
   localparam logic [4:0] S_LR1   = 5'd18;
   localparam logic [4:0] S_LR2   = 5'd19;
   localparam logic [4:0] S_OUT   = 5'd20;

   localparam int V_W    = 41;
   localparam int DLT_W  = 51;
   localparam int WSUM_W = DLT_W + 2;
   localparam int LSUM_W = 87;

   // configuration registers
   logic signed [ERR_W-1:0]   out_max_ff, out_min_ff;
   logic [CFG16_W-1:0]        db_ratio_ff, gain_ff;
   logic [RATE_W-1:0]         rate_ff [3];
   logic signed [WGT_W-1:0]   start_wgt_ff;

   // controller state and work registers
   logic [4:0]                state_ff, state_in;
   logic signed [WGT_W-1:0]   weight_ff [3];
   logic signed [ERR_W-1:0]   prev_ff, e_ff;
   logic signed [TOT_W-1:0]   total_ff;
   logic signed [ERR_W:0]     x2_ff;
   logic                      dead_ff;
   logic signed [63:0]        acc_ff;
   logic                      neg_ff, aneg_ff;
   logic [62:0]               mag_ff, aabs_ff;
   logic [DIVS_W-1:0]         s_ff;
   logic [47:0]               dlo_ff;
   logic signed [V_W-1:0]     v_ff;
   logic signed [ERR_W-1:0]   drive_ff;
   logic                      clamped_ff;
   logic signed [31:0]        ed_ff;
   logic [55:0]               pl_ff;
   logic [1:0]                k_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   // shared units
   logic signed [MUL_W-1:0]   op_a, op_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      div_start, div_done;
   logic [DIVD_W-1:0]         div_dividend;
   logic [QUO_W-1:0]          quotient;

   logic                      req_accept;
   logic                      out_free;

   snapid_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   snapid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (s_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // helper terms
   logic signed [TOT_W:0]      tot_sum;
   logic signed [ERR_W:0]      span;
   logic [ERR_W:0]             e_abs;
   logic signed [PROD_W-1:0]   db_lhs;
   logic [32:0]                wabs [3];
   logic signed [63:0]         num;
   logic signed [MUL_W-1:0]    term_k;
   logic [LSUM_W-1:0]          lsum;
   logic [DLT_W-1:0]           dmag;
   logic signed [WSUM_W-1:0]   wsum;
   logic signed [WGT_W-1:0]    wsat;
   logic [QUO_W-9:0]           vmag;

   assign tot_sum = {total_ff[TOT_W-1], total_ff} + {{(TOT_W+1-ERR_W){e_ff[ERR_W-1]}}, e_ff};
   assign span    = {out_max_ff[ERR_W-1], out_max_ff} - {out_min_ff[ERR_W-1], out_min_ff};
   assign e_abs   = e_ff[ERR_W-1] ? (ERR_W+1)'(-{e_ff[ERR_W-1], e_ff})
                                  : {1'b0, e_ff};
   assign db_lhs  = signed'({{(PROD_W-ERR_W-17){1'b0}}, e_abs, 16'b0});
   assign num     = acc_ff + prod[63:0];
   assign vmag    = quotient[QUO_W-1:8];

   // weight magnitudes for the normalising sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wabs[i] = weight_ff[i][WGT_W-1] ? 33'(-{weight_ff[i][WGT_W-1], weight_ff[i]})
                                         : {1'b0, weight_ff[i]};
      end
   end

   // learning term for the weight in work
   always_comb begin
      case (k_ff)
         2'd0:    term_k = MUL_W'(total_ff);
         2'd1:    term_k = MUL_W'(e_ff);
         default: term_k = MUL_W'(x2_ff);
      endcase
   end

   // weight step: floor(|ed*term| * rate / 2^36), signed, then saturate
   assign lsum = {prod[54:0], 32'b0} + {31'b0, pl_ff};
   assign dmag = lsum[LSUM_W-1:36];
   assign wsum = aneg_ff ? (WSUM_W'(weight_ff[k_ff]) - signed'({2'b0, dmag}))
                         : (WSUM_W'(weight_ff[k_ff]) + signed'({2'b0, dmag}));
   always_comb begin
      if (wsum > signed'(WSUM_W'({1'b0, {(WGT_W-1){1'b1}}})))
         wsat = {1'b0, {(WGT_W-1){1'b1}}};
      else if (wsum < -signed'(WSUM_W'({1'b0, {(WGT_W-1){1'b1}}})) - 1)
         wsat = {1'b1, {(WGT_W-1){1'b0}}};
      else
         wsat = wsum[WGT_W-1:0];
   end

   // divider operands: |num| * gain assembled from two partial products
   assign div_start    = (state_ff == S_G2);
   assign div_dividend = {prod[46:0], 32'b0} + {31'b0, dlo_ff};

   // multiplier operand selection
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_DB: begin
            op_a = MUL_W'(span);
            op_b = MUL_W'({1'b0, db_ratio_ff});
         end
         S_M0: begin
            op_a = MUL_W'(weight_ff[0]);
            op_b = MUL_W'(total_ff);
         end
         S_M1: begin
            op_a = MUL_W'(weight_ff[1]);
            op_b = MUL_W'(e_ff);
         end
         S_M2: begin
            op_a = MUL_W'(weight_ff[2]);
            op_b = MUL_W'(x2_ff);
         end
         S_G0: begin
            op_a = signed'({1'b0, mag_ff[31:0]});
            op_b = MUL_W'({1'b0, gain_ff});
         end
         S_G1: begin
            op_a = signed'({2'b0, mag_ff[62:32]});
            op_b = MUL_W'({1'b0, gain_ff});
         end
         S_ED: begin
            op_a = MUL_W'(e_ff);
            op_b = MUL_W'(drive_ff);
         end
         S_LA: begin
            op_a = MUL_W'(ed_ff);
            op_b = term_k;
         end
         S_LR0: begin
            op_a = signed'({1'b0, aabs_ff[31:0]});
            op_b = MUL_W'({1'b0, rate_ff[k_ff]});
         end
         S_LR1: begin
            op_a = signed'({2'b0, aabs_ff[62:32]});
            op_b = MUL_W'({1'b0, rate_ff[k_ff]});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_accept) state_in = S_DB;
         S_DB:    state_in = S_M0;
         S_M0:    state_in = (db_lhs <= prod) ? S_CLAMP : S_M1;
         S_M1:    state_in = S_M2;
         S_M2:    state_in = S_M3;
         S_M3:    state_in = S_ABS;
         S_ABS:   state_in = (s_ff == '0) ? S_CLAMP : S_G0;
         S_G0:    state_in = S_G1;
         S_G1:    state_in = S_G2;
         S_G2:    state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_VAL;
         S_VAL:   state_in = S_CLAMP;
         S_CLAMP: state_in = dead_ff ? S_OUT : S_ED;
         S_ED:    state_in = S_EDL;
         S_EDL:   state_in = S_LA;
         S_LA:    state_in = S_LAB;
         S_LAB:   state_in = S_LR0;
         S_LR0:   state_in = S_LR1;
         S_LR1:   state_in = S_LR2;
         S_LR2:   state_in = (k_ff == 2'd2) ? S_OUT : S_LA;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_max_ff   <= 16'sd3277;
         out_min_ff   <= -16'sd3277;
         db_ratio_ff  <= 16'd655;
         gain_ff      <= 16'd256;
         rate_ff[0]   <= 24'd1677;
         rate_ff[1]   <= 24'd1677;
         rate_ff[2]   <= 24'd1677;
         start_wgt_ff <= 32'sd16777216;
      end else if (csr_we) begin
         case (csr_index)
            REG_OUT_MAX:   out_max_ff   <= csr_wdata[ERR_W-1:0];
            REG_OUT_MIN:   out_min_ff   <= csr_wdata[ERR_W-1:0];
            REG_DB_RATIO:  db_ratio_ff  <= csr_wdata[CFG16_W-1:0];
            REG_GAIN:      gain_ff      <= csr_wdata[CFG16_W-1:0];
            REG_RATE_I:    rate_ff[0]   <= csr_wdata[RATE_W-1:0];
            REG_RATE_P:    rate_ff[1]   <= csr_wdata[RATE_W-1:0];
            REG_RATE_D:    rate_ff[2]   <= csr_wdata[RATE_W-1:0];
            REG_START_WGT: start_wgt_ff <= csr_wdata[WGT_W-1:0];
            default: ;
         endcase
      end
   end

   // controller state: weights and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         weight_ff[0] <= 32'sd16777216;
         weight_ff[1] <= 32'sd16777216;
         weight_ff[2] <= 32'sd16777216;
         prev_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // restart clears history before the sample is used
         if (req_accept && req_data.restart) begin
            weight_ff[0] <= start_wgt_ff;
            weight_ff[1] <= start_wgt_ff;
            weight_ff[2] <= start_wgt_ff;
            prev_ff      <= '0;
            total_ff     <= '0;
         end
         // saturating error sum
         if (state_ff == S_DB) begin
            if (tot_sum[TOT_W] != tot_sum[TOT_W-1])
               total_ff <= {tot_sum[TOT_W], {(TOT_W-1){!tot_sum[TOT_W]}}};
            else
               total_ff <= tot_sum[TOT_W-1:0];
         end
         if (state_ff == S_LR2)
            weight_ff[k_ff] <= wsat;
         // result into the output register
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            prev_ff      <= e_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath work registers
   always_ff @(posedge clock) begin
      if (req_accept)
         e_ff <= req_data.error_in;
      case (state_ff)
         S_DB: begin
            x2_ff <= {e_ff[ERR_W-1], e_ff} - {prev_ff[ERR_W-1], prev_ff};
         end
         S_M0: begin
            dead_ff <= (db_lhs <= prod);
            v_ff    <= '0;
            s_ff    <= DIVS_W'(wabs[0]) + DIVS_W'(wabs[1]) + DIVS_W'(wabs[2]);
         end
         S_M1:  acc_ff <= prod[63:0];
         S_M2:  acc_ff <= num;
         S_M3:  acc_ff <= num;
         S_ABS: begin
            neg_ff <= acc_ff[63];
            mag_ff <= acc_ff[63] ? 63'(-acc_ff) : acc_ff[62:0];
            v_ff   <= '0;
         end
         S_G1:  dlo_ff <= prod[47:0];
         S_VAL: v_ff <= neg_ff ? -V_W'({1'b0, vmag}) : V_W'({1'b0, vmag});
         S_CLAMP: begin
            if (v_ff > V_W'(out_max_ff)) begin
               drive_ff   <= out_max_ff;
               clamped_ff <= 1'b1;
            end else if (v_ff < V_W'(out_min_ff)) begin
               drive_ff   <= out_min_ff;
               clamped_ff <= 1'b1;
            end else begin
               drive_ff   <= v_ff[ERR_W-1:0];
               clamped_ff <= 1'b0;
            end
         end
         S_EDL: begin
            ed_ff <= prod[31:0];
            k_ff  <= 2'd0;
         end
         S_LAB: begin
            aneg_ff <= prod[63];
            aabs_ff <= prod[63] ? 63'(-prod[63:0]) : prod[62:0];
         end
         S_LR1: pl_ff <= prod[55:0];
         S_LR2: k_ff <= k_ff + 2'd1;
         S_OUT: begin
            if (out_free) begin
               rsp_ff.drive       <= drive_ff;
               rsp_ff.in_deadband <= dead_ff;
               rsp_ff.clamped     <= clamped_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted transaction keeps the input side closed next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("input not held off after acceptance");

   // a clamped result sits at one of the limits
   a_clamp_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.clamped) |->
      (rsp_data.drive == out_max_ff || rsp_data.drive == out_min_ff))
      else $error("clamped drive off the limits");

   // inside the deadband the drive is zero unless the limits exclude zero
   a_deadband_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.in_deadband && !rsp_data.clamped) |->
      (rsp_data.drive == '0))
      else $error("nonzero drive inside deadband");

   // the divider only finishes while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide step");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the single-neuron adaptive pid block. A built-in
// predictor runs alongside the block, and every drive, deadband flag and
// clamp flag is checked against it under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
   import snapid_pkg::*;

   localparam longint CYCLE_LIMIT = 2000000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   single_neuron_adaptive_pid u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // controller settings as last written
   longint lim_hi, lim_lo, db_ratio, gain, rate_i, rate_p, rate_d, wgt_start;
   // controller state
   longint err_prev, err_sum, w_int, w_prop, w_diff;

   rsp_type drive_queue[$];
   int      fail_count;
   int      sent_count;
   int      checked_count;
   int      deadband_count;
   int      clamp_count;
   longint  cycle_count;
   bit      quiet;
   int      hold_tag;
   int      hold_len;

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------
   function automatic longint saturate(logic signed [127:0] v, int bits);
      logic signed [127:0] top;
      logic signed [127:0] bottom;
      top    = (128'sd1 <<< (bits - 1)) - 128'sd1;
      bottom = -top - 128'sd1;
      if (v > top) return longint'(top);
      if (v < bottom) return longint'(bottom);
      return longint'(v);
   endfunction

   function automatic longint adapt_weight(longint w, longint rate, longint ed, longint term);
      logic signed [127:0] prod;
      logic signed [127:0] mag;
      logic signed [127:0] delta;
      prod  = 128'(ed) * 128'(term);
      mag   = (prod < 0) ? -prod : prod;
      delta = (mag * 128'(rate)) >>> 36;
      if (prod < 0) delta = -delta;
      return saturate(128'(w) + delta, WGT_W);
   endfunction

   function automatic rsp_type predict_drive(req_type sample);
      longint              e, x0, x1, x2, ed;
      logic signed [127:0] wsum, num, mag, v;
      bit                  dead;
      rsp_type             r;
      e = longint'(sample.error_in);
      if (sample.restart) begin
         w_int    = wgt_start;
         w_prop   = wgt_start;
         w_diff   = wgt_start;
         err_sum  = 0;
         err_prev = 0;
      end
      err_sum = saturate(128'(err_sum) + 128'(e), TOT_W);
      x0 = err_sum;
      x1 = e;
      x2 = e - err_prev;
      dead = ((e < 0 ? -e : e) * 65536) <= ((lim_hi - lim_lo) * db_ratio);
      v = 0;
      if (!dead) begin
         wsum = 128'(w_int < 0 ? -w_int : w_int) + 128'(w_prop < 0 ? -w_prop : w_prop)
              + 128'(w_diff < 0 ? -w_diff : w_diff);
         if (wsum != 0) begin
            num = 128'(w_int) * 128'(x0) + 128'(w_prop) * 128'(x1)
                + 128'(w_diff) * 128'(x2);
            mag = (num < 0) ? -num : num;
            v   = ((mag * 128'(gain)) / wsum) >>> 8;
            if (num < 0) v = -v;
         end
      end
      r.clamped = 1'b1;
      if (v > 128'(lim_hi)) r.drive = lim_hi[ERR_W-1:0];
      else if (v < 128'(lim_lo)) r.drive = lim_lo[ERR_W-1:0];
      else begin
         r.drive   = v[ERR_W-1:0];
         r.clamped = 1'b0;
      end
      r.in_deadband = dead;
      if (!dead) begin
         ed     = e * longint'(r.drive);
         w_int  = adapt_weight(w_int, rate_i, ed, x0);
         w_prop = adapt_weight(w_prop, rate_p, ed, x1);
         w_diff = adapt_weight(w_diff, rate_d, ed, x2);
      end
      err_prev = e;
      return r;
   endfunction

   // mostly short idle runs, now and then a long one
   function automatic int idle_len();
      if (quiet) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   // ---------------------------------------------------------------------------
   // receiver stall, with an occasional long hold-off
   // ---------------------------------------------------------------------------
   int run_left;
   int hold_left;
   int hold_seen;
   always @(posedge clock) begin
      if (hold_seen != hold_tag) begin
         hold_seen = hold_tag;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (run_left > 0) begin
         run_left--;
      end else begin
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
         run_left = idle_len();
      end
   end

   // result checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_queue.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $realtime, rsp_data);
            fail_count++;
         end else begin
            want = drive_queue.pop_front();
            checked_count++;
            if (want.in_deadband) deadband_count++;
            if (want.clamped) clamp_count++;
            if (rsp_data.drive !== want.drive) begin
               $display("%0t: drive expected %0d actual %0d", $realtime,
                        want.drive, rsp_data.drive);
               fail_count++;
            end
            if (rsp_data.in_deadband !== want.in_deadband) begin
               $display("%0t: in_deadband expected %b actual %b", $realtime,
                        want.in_deadband, rsp_data.in_deadband);
               fail_count++;
            end
            if (rsp_data.clamped !== want.clamped) begin
               $display("%0t: clamped expected %b actual %b", $realtime,
                        want.clamped, rsp_data.clamped);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // shared tasks
   // ---------------------------------------------------------------------------
   task automatic send_sample(logic signed [ERR_W-1:0] e, logic restart);
      int      gap;
      req_type item;
      gap = idle_len();
      item.error_in = e;
      item.restart  = restart;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      drive_queue.push_back(predict_drive(item));
      sent_count++;
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // every sample gives a result, so an empty queue means the block is idle
   task automatic wait_idle();
      end_burst();
      wait (drive_queue.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_OUT_MAX:   lim_hi    = longint'(signed'(value[15:0]));
         REG_OUT_MIN:   lim_lo    = longint'(signed'(value[15:0]));
         REG_DB_RATIO:  db_ratio  = value & 64'hFFFF;
         REG_GAIN:      gain      = value & 64'hFFFF;
         REG_RATE_I:    rate_i    = value & 64'hFFFFFF;
         REG_RATE_P:    rate_p    = value & 64'hFFFFFF;
         REG_RATE_D:    rate_d    = value & 64'hFFFFFF;
         REG_START_WGT: wgt_start = longint'(signed'(value[31:0]));
         default: ;
      endcase
   endtask

   task automatic write_all(longint hi, longint lo, longint ratio, longint g,
                            longint ri, longint rp, longint rd, longint sw);
      write_reg(REG_OUT_MAX, hi);
      write_reg(REG_OUT_MIN, lo);
      write_reg(REG_DB_RATIO, ratio);
      write_reg(REG_GAIN, g);
      write_reg(REG_RATE_I, ri);
      write_reg(REG_RATE_P, rp);
      write_reg(REG_RATE_D, rd);
      write_reg(REG_START_WGT, sw);
   endtask

   function automatic logic signed [ERR_W-1:0] random_error();
      case ($urandom_range(0, 4))
         0:       return ERR_W'($urandom);
         1:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         default: return ERR_W'($signed($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   task automatic test_directed();
      // reset settings: zero error, deadband edge, field extremes, restart
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd65, 1'b0);
      send_sample(-16'sd65, 1'b0);
      send_sample(16'sd66, 1'b0);
      send_sample(-16'sd66, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sh8000, 1'b1);
      wait_idle();
      // zero weights: empty weight sum
      write_reg(REG_START_WGT, 0);
      send_sample(16'sd3000, 1'b1);
      send_sample(-16'sd3000, 1'b0);
      wait_idle();
      // inverted limits and a negative span: no deadband, clamp order
      write_all(-1000, 1000, 65535, 65535, 16777215, 16777215, 16777215, 64'h7FFFFFFF);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd500, 1'b0);
      send_sample(-16'sd500, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      wait_idle();
      // widest limits, deadband only at zero error, most negative start weight
      write_all(32767, -32768, 0, 65535, 0, 16777215, 1, 64'h80000000);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sd1, 1'b0);
      wait_idle();
      // whole span inside the deadband
      write_all(32767, -32768, 65535, 0, 1677, 1677, 1677, 16777216);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_settings(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_all(($urandom_range(0, 3) == 0) ? 64'(16'($urandom))
                                               : longint'($urandom_range(0, 32767)),
                   ($urandom_range(0, 3) == 0) ? 64'(16'($urandom))
                                               : -longint'($urandom_range(0, 32768)),
                   ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2000) : $urandom_range(0, 65535),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1024),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215) : $urandom_range(0, 20000),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215) : $urandom_range(0, 20000),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215) : $urandom_range(0, 20000),
                   ($urandom_range(0, 3) == 0) ? 64'($urandom) : $urandom_range(0, 1 << 26));
         quiet = (p % 4 == 3);
         send_sample(random_error(), 1'b1);
         for (int i = 1; i < per_phase; i++)
            send_sample(random_error(), $urandom_range(0, 31) == 0);
         wait_idle();
         quiet = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      write_all(3277, -3277, 655, 256, 1677, 1677, 1677, 16777216);
      // long receiver hold while the sender keeps offering
      hold_len = 400;
      hold_tag++;
      for (int i = 0; i < 12; i++)
         send_sample(random_error(), i == 0);
      // sender waits for every result before going on
      wait_idle();
      for (int i = 0; i < 12; i++)
         send_sample(random_error(), 1'b0);
      wait_idle();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      lim_hi    = 3277;
      lim_lo    = -3277;
      db_ratio  = 655;
      gain      = 256;
      rate_i    = 1677;
      rate_p    = 1677;
      rate_d    = 1677;
      wgt_start = 16777216;
      err_prev  = 0;
      err_sum   = 0;
      w_int     = 16777216;
      w_prop    = 16777216;
      w_diff    = 16777216;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_settings(8, 60);
      test_backpressure();

      wait_idle();
      repeat (100) @(posedge clock);
      $display("run covered %0d samples, %0d results checked, %0d in deadband, %0d clamped",
               sent_count, checked_count, deadband_count, clamp_count);
      $display("settings covered limits, deadband, gain, rates, restart weights and stalls");
      if (fail_count == 0 && drive_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
